// ----- hw/rtl/mdr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mdr_pkg;

  localparam int WORD_BITS = 64;
  localparam int KNOWN_COUNT = 12;
  localparam int QUOT_BITS = 128;
  localparam int STEP_BITS = 7;

  typedef struct packed {
    logic [WORD_BITS-1:0] magic;
    logic [2:0]           extra;
    logic [WORD_BITS-1:0] div;
  } known_t;

  typedef struct packed {
    logic                 start;
    logic [6:0]           shift;
    logic [WORD_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 busy;
    logic [QUOT_BITS-1:0] quot;
    logic [WORD_BITS-1:0] rem;
  } div_rsp_t;

  // Look up a known 32-bit magic; returns zero when absent.
  function automatic logic [WORD_BITS-1:0] known_lookup(
      input logic [WORD_BITS-1:0] magic, input logic [6:0] extra);
    known_t tab [KNOWN_COUNT];
    logic [WORD_BITS-1:0] res;
    tab[0]  = '{64'hAAAAAAAB, 3'd1, 64'd3};
    tab[1]  = '{64'hCCCCCCCD, 3'd2, 64'd5};
    tab[2]  = '{64'hAAAAAAAB, 3'd2, 64'd6};
    tab[3]  = '{64'h24924925, 3'd0, 64'd7};
    tab[4]  = '{64'h38E38E39, 3'd1, 64'd9};
    tab[5]  = '{64'hCCCCCCCD, 3'd3, 64'd10};
    tab[6]  = '{64'hBA2E8BA3, 3'd3, 64'd11};
    tab[7]  = '{64'hAAAAAAAB, 3'd3, 64'd12};
    tab[8]  = '{64'h51EB851F, 3'd3, 64'd25};
    tab[9]  = '{64'h51EB851F, 3'd5, 64'd100};
    tab[10] = '{64'h10624DD3, 3'd6, 64'd1000};
    tab[11] = '{64'h80808081, 3'd7, 64'd255};
    res = '0;
    for (int i = KNOWN_COUNT - 1; i >= 0; i--) begin
      if (tab[i].magic == magic && {4'd0, tab[i].extra} == extra) begin
        res = tab[i].div;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mdr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mdr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] magic;
  logic [6:0]  shift_total;
  logic [6:0]  operand_width;
  modport source (output valid, magic, shift_total, operand_width, input ready);
  modport sink (input valid, magic, shift_total, operand_width, output ready);
endinterface

interface mdr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] divisor;
  logic        found;
  logic        from_table;
  modport source (output valid, divisor, found, from_table, input ready);
  modport sink (input valid, divisor, found, from_table, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mdr_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mdr_divider
  import mdr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_BITS-1:0] idx_r, idx_nxt;
  logic [6:0]           shift_r, shift_nxt;
  logic [WORD_BITS-1:0] dvs_r, dvs_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [QUOT_BITS-1:0] quot_r, quot_nxt;
  logic [WORD_BITS:0]   shifted;
  logic                 take;

  // One restoring step per cycle, numerator bit i is (i == shift)
  assign shifted = {rem_r, (idx_r == shift_r)};
  assign take = shifted[WORD_BITS] || (shifted[WORD_BITS-1:0] >= dvs_r);

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      idx_nxt   = STEP_BITS'(QUOT_BITS - 1);
      shift_nxt = req.shift;
      dvs_nxt   = req.divisor;
      rem_nxt   = '0;
      quot_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = take ? shifted[WORD_BITS-1:0] - dvs_r : shifted[WORD_BITS-1:0];
      quot_nxt = {quot_r[QUOT_BITS-2:0], take};
      idx_nxt  = idx_r - 1'b1;
      if (idx_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    idx_r   <= idx_nxt;
    shift_r <= shift_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
  end

  assign rsp = '{done: done_r, busy: busy_r, quot: quot_r, rem: rem_r};

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without run");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r && !$past(req.start))) else $error("busy and done");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("start lost");

endmodule
`default_nettype wire

// ----- hw/rtl/magic_divisor_recovery_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A table hit or zero operand goes straight to the output; otherwise up to four
// divisions run (candidate, then d, d+1, d-1).
// Throughput: one word at a time; the 128-step bit-serial divider sets the rate.
// The input is not ready while a word is in work or a result waits.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
module magic_divisor_recovery_core
  import mdr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mdr_in_if.sink    in_ch,
  mdr_out_if.source out_ch
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CAND  = 6'b000010,
    ST_CWAIT = 6'b000100,
    ST_VER   = 6'b001000,
    ST_VWAIT = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] magic_r, magic_nxt;
  logic [6:0]           shift_r, shift_nxt;
  logic [6:0]           width_r, width_nxt;
  logic [WORD_BITS-1:0] cand_r, cand_nxt;
  logic [WORD_BITS-1:0] try_r, try_nxt;
  logic [1:0]           alt_r, alt_nxt;
  logic [WORD_BITS-1:0] res_r, res_nxt;
  logic                 tab_r, tab_nxt;
  div_req_t             req;
  div_rsp_t             rsp;
  logic [WORD_BITS-1:0] tab_hit;
  logic [6:0]           w_sat;
  logic [QUOT_BITS-1:0] q_adj;
  logic [WORD_BITS:0]   mag_m1, mag_p1, lim;
  logic                 ge, le;

  mdr_divider u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign w_sat   = (in_ch.operand_width > 7'(WORD_BITS)) ? 7'(WORD_BITS) : in_ch.operand_width;
  assign tab_hit = (w_sat <= 7'd32 && in_ch.shift_total >= 7'd32) ?
                   known_lookup(in_ch.magic, in_ch.shift_total - 7'd32) : '0;

  // Quotient after rounding: half up for the candidate (truncated when shift < 64), ceiling for checks
  always_comb begin
    q_adj = rsp.quot;
    if (state_r == ST_CWAIT) begin
      if (shift_r >= 7'd64 && rsp.rem >= magic_r - rsp.rem) q_adj = rsp.quot + 1'b1;
    end else if (rsp.rem != '0) begin
      q_adj = rsp.quot + 1'b1;
    end
  end

  assign mag_m1 = {1'b0, magic_r} - 1'b1;
  assign mag_p1 = {1'b0, magic_r} + 1'b1;
  assign ge = (q_adj[QUOT_BITS-1:WORD_BITS] != '0) || ({1'b0, q_adj[WORD_BITS-1:0]} >= mag_m1);
  assign le = (q_adj[QUOT_BITS-1:WORD_BITS+1] == '0) && (q_adj[WORD_BITS:0] <= mag_p1);
  assign lim = (width_r >= 7'(WORD_BITS)) ? {1'b1, {WORD_BITS{1'b0}}} :
               ({{WORD_BITS{1'b0}}, 1'b1} << width_r[5:0]);

  // Sequence: candidate division, then up to three verify divisions
  always_comb begin
    state_nxt = state_r;
    magic_nxt = magic_r;
    shift_nxt = shift_r;
    width_nxt = width_r;
    cand_nxt  = cand_r;
    try_nxt   = try_r;
    alt_nxt   = alt_r;
    res_nxt   = res_r;
    tab_nxt   = tab_r;
    req       = '{start: 1'b0, shift: shift_r, divisor: try_r};
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          magic_nxt = in_ch.magic;
          shift_nxt = in_ch.shift_total;
          width_nxt = w_sat;
          res_nxt   = tab_hit;
          tab_nxt   = tab_hit != '0;
          try_nxt   = in_ch.magic;
          if (tab_hit != '0 || in_ch.magic == '0 || in_ch.shift_total == '0) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_CAND;
          end
        end
      end
      ST_CAND: begin
        req.start = 1'b1;
        state_nxt = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (rsp.done) begin
          cand_nxt = q_adj[WORD_BITS-1:0];
          try_nxt  = q_adj[WORD_BITS-1:0];
          alt_nxt  = 2'd0;
          if (q_adj[QUOT_BITS-1:WORD_BITS] != '0 || q_adj[WORD_BITS-1:0] < 64'd2 ||
              {1'b0, q_adj[WORD_BITS-1:0]} > lim) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_VER;
          end
        end
      end
      ST_VER: begin
        req.start = 1'b1;
        state_nxt = ST_VWAIT;
      end
      ST_VWAIT: begin
        if (rsp.done) begin
          if (ge && le) begin
            res_nxt   = try_r;
            state_nxt = ST_OUT;
          end else if (alt_r == 2'd0 && cand_r != '1) begin
            alt_nxt   = 2'd1;
            try_nxt   = cand_r + 1'b1;
            state_nxt = ST_VER;
          end else if (alt_r != 2'd2 && cand_r - 1'b1 >= 64'd2) begin
            alt_nxt   = 2'd2;
            try_nxt   = cand_r - 1'b1;
            state_nxt = ST_VER;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    magic_r <= magic_nxt;
    shift_r <= shift_nxt;
    width_r <= width_nxt;
    cand_r  <= cand_nxt;
    try_r   <= try_nxt;
    alt_r   <= alt_nxt;
    res_r   <= res_nxt;
    tab_r   <= tab_nxt;
  end

  assign in_ch.ready       = state_r == ST_IDLE;
  assign out_ch.valid      = state_r == ST_OUT;
  assign out_ch.divisor    = res_r;
  assign out_ch.found      = res_r != '0;
  assign out_ch.from_table = tab_r;

  a_tab_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.from_table) |-> out_ch.found) else $error("table w/o divisor");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> !rsp.busy) else $error("divider runs at output");

endmodule
`default_nettype wire
